// File: hw/rtl/rgb_conv3x3_line_buffer_core_defines.svh
// ----------------------------------------------------------------------------
// RGB 3x3 convolution core: assertion macros
// Shared property macros, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RGB_CONV3X3_LINE_BUFFER_CORE_DEFINES_SVH
`define RGB_CONV3X3_LINE_BUFFER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBCV_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGBCV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/rgbcv_pkg.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution core: shared definitions
// Sizes, register indexes, pixel and kernel types and frame size clamping.
// ----------------------------------------------------------------------------
package rgbcv_pkg;

   localparam int MAX_LINE    = 2048;
   localparam int KERNEL_DIM  = 3;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MIN_WIDTH   = 4;
   localparam int COL_W       = $clog2(MAX_LINE);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int WIDTH_W     = 12;
   localparam int HEIGHT_W    = 13;
   localparam int CHAN_W      = 8;
   localparam int CHANNELS    = 3;
   localparam int PIX_W       = CHAN_W * CHANNELS;
   localparam int COEF_W      = 16;
   localparam int FRAC_BITS   = 7;
   localparam int CSR_DATA_W  = COEF_W * KERNEL_DIM;
   localparam int CSR_INDEX_W = 3;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(480);

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_TOP     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_MID     = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_BOT     = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(4);

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef pixel_type [KERNEL_DIM-1:0][KERNEL_DIM-1:0] window_type;
   typedef logic [COEF_W-1:0] coef_type;
   typedef coef_type [KERNEL_DIM-1:0][KERNEL_DIM-1:0] kernel_type;

   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } filt_ctrl_type;

   function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] raw);
      logic [WIDTH_W-1:0] res;
      if (32'(raw) < MIN_WIDTH) begin
         res = WIDTH_W'(MIN_WIDTH);
      end else if (32'(raw) > MAX_LINE) begin
         res = WIDTH_W'(MAX_LINE);
      end else begin
         res = raw;
      end
      return res;
   endfunction

   // Returns the number of lines less one.
   function automatic logic [ROW_W-1:0] clamp_height_m1(input logic [HEIGHT_W-1:0] raw);
      logic [HEIGHT_W-1:0] tmp;
      logic [ROW_W-1:0]    res;
      tmp = raw - HEIGHT_W'(1);
      if (raw == '0) begin
         res = '0;
      end else if (32'(raw) > MAX_HEIGHT) begin
         res = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         res = tmp[ROW_W-1:0];
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/rgb_conv3x3_line_buffer_core.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution core with line buffering
// Accepts one input word per cycle while the output is not stalled, with no gaps between frames.
// A result word is registered in the input, product and output stages in turn.
// The rate is set by the line memory: one read and one write per word.
// Reset clears the counters and pipeline valid flags and sets the registers to defaults.
// The line memory is not cleared and takes no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "rgb_conv3x3_line_buffer_core_defines.svh"

module rgb_conv3x3_line_buffer_core
   import rgbcv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PIX_W-1:0]       req_tdata,   // pix_blue, pix_green, pix_red
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [PIX_W-1:0]       rsp_tdata,   // out_blue, out_green, out_red
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {ST_PRE, ST_RUN, ST_TAIL} state_type;

   kernel_type           kernel_ff;
   logic [WIDTH_W-1:0]   width_raw_ff;
   logic [HEIGHT_W-1:0]  height_raw_ff;

   state_type            state_ff, state_in;
   logic [WIDTH_W-1:0]   pre_cnt_ff, pre_cnt_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [ROW_W-1:0]     out_row_ff, out_row_in;
   logic [COL_W-1:0]     ins_col_ff, ins_col_in;
   logic [WIDTH_W-1:0]   frame_w_ff, frame_w_in;
   logic [ROW_W-1:0]     frame_h_m1_ff, frame_h_m1_in;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_emit_ff, s1_emit_in;
   logic                 s1_last_ff, s1_last_in;
   logic                 s1_top_ok_ff, s1_top_ok_in;
   logic                 s1_left_ok_ff, s1_left_ok_in;
   logic                 s1_right_ok_ff, s1_right_ok_in;
   pixel_type            s1_pix_ff, s1_pix_in;
   logic [COL_W-1:0]     s1_col_ff, s1_col_in;
   window_type           win_ff, win_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 req_accept;
   logic                 first_item;
   logic [WIDTH_W-1:0]   cur_w;
   logic [ROW_W-1:0]     cur_h_m1;
   logic [COL_W-1:0]     col_last;
   logic                 at_col_last;
   logic                 at_row_last;
   logic                 out_ready;
   logic                 s2_free;
   logic                 s1_fire;
   logic [2*PIX_W-1:0]   ram_rd;
   window_type           taps;
   filt_ctrl_type        filt_ctrl;
   pixel_type            filt_pix;

   // Handshake between the input register, the product stage and the output.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s2_free    = !s2_valid_ff || out_ready;
   assign s1_fire    = s1_valid_ff && (!s1_emit_ff || s2_free);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign filt_ctrl.prod_en = s1_fire && s1_emit_ff;
   assign filt_ctrl.sum_en  = s2_valid_ff && out_ready;

   assign first_item  = (state_ff == ST_PRE) && (pre_cnt_ff == '0);
   assign cur_w       = first_item ? clamp_width(width_raw_ff) : frame_w_ff;
   assign cur_h_m1    = first_item ? clamp_height_m1(height_raw_ff) : frame_h_m1_ff;
   assign col_last    = COL_W'(cur_w - WIDTH_W'(1));
   assign at_col_last = (out_col_ff == col_last);
   assign at_row_last = (out_row_ff == cur_h_m1);

   always_comb begin
      state_in       = state_ff;
      pre_cnt_in     = pre_cnt_ff;
      out_col_in     = out_col_ff;
      out_row_in     = out_row_ff;
      ins_col_in     = ins_col_ff;
      frame_w_in     = frame_w_ff;
      frame_h_m1_in  = frame_h_m1_ff;
      s1_emit_in     = s1_emit_ff;
      s1_last_in     = s1_last_ff;
      s1_top_ok_in   = s1_top_ok_ff;
      s1_left_ok_in  = s1_left_ok_ff;
      s1_right_ok_in = s1_right_ok_ff;
      s1_pix_in      = s1_pix_ff;
      s1_col_in      = s1_col_ff;
      if (req_accept) begin
         frame_w_in     = cur_w;
         frame_h_m1_in  = cur_h_m1;
         ins_col_in     = (ins_col_ff == col_last) ? '0 : ins_col_ff + COL_W'(1);
         s1_emit_in     = 1'b0;
         s1_last_in     = 1'b0;
         s1_top_ok_in   = (out_row_ff != '0);
         s1_left_ok_in  = (out_col_ff != '0);
         s1_right_ok_in = !at_col_last;
         s1_pix_in      = pixel_type'(req_tdata);
         s1_col_in      = ins_col_ff;
         unique case (state_ff)
            ST_PRE: begin
               pre_cnt_in = pre_cnt_ff + WIDTH_W'(1);
               if (pre_cnt_ff == WIDTH_W'(cur_w + WIDTH_W'(1))) begin
                  state_in = ST_RUN;
               end
            end
            ST_RUN: begin
               s1_emit_in = 1'b1;
               s1_last_in = at_col_last && at_row_last;
               if (at_col_last) begin
                  out_col_in = '0;
                  if (at_row_last) begin
                     state_in = ST_TAIL;
                  end else begin
                     out_row_in = out_row_ff + ROW_W'(1);
                  end
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
            ST_TAIL: begin
               state_in   = ST_PRE;
               pre_cnt_in = '0;
               ins_col_in = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
            default: begin
               state_in = ST_PRE;
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s2_valid_in  = filt_ctrl.prod_en ? 1'b1 : (out_ready ? 1'b0 : s2_valid_ff);
      rsp_valid_in = filt_ctrl.sum_en ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // The window's newest column holds the previous word and the two words
   // one and two lines above it.
   always_comb begin
      win_in = win_ff;
      if (s1_fire) begin
         for (int m = 0; m < KERNEL_DIM; m++) begin
            for (int n = 0; n < KERNEL_DIM - 1; n++) begin
               win_in[m][n] = win_ff[m][n+1];
            end
         end
         win_in[0][KERNEL_DIM-1] = pixel_type'(ram_rd[2*PIX_W-1 -: PIX_W]);
         win_in[1][KERNEL_DIM-1] = pixel_type'(ram_rd[PIX_W-1:0]);
         win_in[2][KERNEL_DIM-1] = s1_pix_ff;
      end
   end

   // Pixels beyond the top, left and right image borders count as zero.
   always_comb begin
      for (int m = 0; m < KERNEL_DIM; m++) begin
         for (int n = 0; n < KERNEL_DIM; n++) begin
            if ((m == 0 && !s1_top_ok_ff) || (n == 0 && !s1_left_ok_ff) ||
                (n == KERNEL_DIM - 1 && !s1_right_ok_ff)) begin
               taps[m][n] = '0;
            end else begin
               taps[m][n] = win_ff[m][n];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff     <= '0;
         width_raw_ff  <= RESET_WIDTH;
         height_raw_ff <= RESET_HEIGHT;
         state_ff      <= ST_PRE;
         pre_cnt_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         ins_col_ff    <= '0;
         frame_w_ff    <= RESET_WIDTH;
         frame_h_m1_ff <= clamp_height_m1(RESET_HEIGHT);
         s1_valid_ff   <= 1'b0;
         s1_emit_ff    <= 1'b0;
         s1_last_ff    <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_COEF_TOP:     kernel_ff[0]  <= csr_wdata;
               CSR_COEF_MID:     kernel_ff[1]  <= csr_wdata;
               CSR_COEF_BOT:     kernel_ff[2]  <= csr_wdata;
               CSR_IMAGE_WIDTH:  width_raw_ff  <= csr_wdata[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: height_raw_ff <= csr_wdata[HEIGHT_W-1:0];
               default: begin
               end
            endcase
         end
         state_ff      <= state_in;
         pre_cnt_ff    <= pre_cnt_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         ins_col_ff    <= ins_col_in;
         frame_w_ff    <= frame_w_in;
         frame_h_m1_ff <= frame_h_m1_in;
         s1_valid_ff   <= s1_valid_in;
         s1_emit_ff    <= s1_emit_in;
         s1_last_ff    <= s1_last_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_top_ok_ff   <= s1_top_ok_in;
      s1_left_ok_ff  <= s1_left_ok_in;
      s1_right_ok_ff <= s1_right_ok_in;
      s1_pix_ff      <= s1_pix_in;
      s1_col_ff      <= s1_col_in;
      win_ff         <= win_in;
   end

   rgbcv_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_LINE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data ({ram_rd[PIX_W-1:0], s1_pix_ff}),
      .rd_en   (req_accept),
      .rd_addr (ins_col_ff),
      .rd_data (ram_rd)
   );

   rgbcv_filter u_filter (
      .clock    (clock),
      .ctrl     (filt_ctrl),
      .taps     (taps),
      .kernel   (kernel_ff),
      .last     (s1_last_ff),
      .pix_out  (filt_pix),
      .last_out (rsp_tlast)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = filt_pix;

   `RGBCV_ASSERT_SAME(a_out_col_range, state_ff == ST_RUN, 32'(out_col_ff) < 32'(frame_w_ff), "output column beyond frame width")
   `RGBCV_ASSERT_SAME(a_ins_col_range, 1'b1, 32'(ins_col_ff) < 32'(frame_w_ff), "line write column beyond frame width")
   `RGBCV_ASSERT_NEXT(a_s2_held, s2_valid_ff && !out_ready, s2_valid_ff, "waiting product stage was dropped")
   `RGBCV_ASSERT_NEXT(a_frame_restart, req_accept && state_ff == ST_TAIL, state_ff == ST_PRE && pre_cnt_ff == '0 && ins_col_ff == '0, "frame did not restart after its final word")

endmodule

// File: hw/rtl/rgbcv_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered, read-first output.
// ----------------------------------------------------------------------------
module rgbcv_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/rgbcv_filter.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution core: filter datapath
// Registered products of the masked window and kernel, then a wrapping Q9.7
// sum per channel truncated toward zero to eight bits.
// ----------------------------------------------------------------------------
module rgbcv_filter
   import rgbcv_pkg::*;
(
   input  logic          clock,
   input  filt_ctrl_type ctrl,
   input  window_type    taps,
   input  kernel_type    kernel,
   input  logic          last,
   output pixel_type     pix_out,
   output logic          last_out
);

   logic [COEF_W-1:0] prod_ff [CHANNELS][KERNEL_DIM][KERNEL_DIM];
   logic [COEF_W-1:0] prod_in [CHANNELS][KERNEL_DIM][KERNEL_DIM];
   logic [COEF_W-1:0] acc [CHANNELS];
   logic              last_s2_ff;
   pixel_type         pix_out_ff;
   pixel_type         pix_out_in;
   logic              last_out_ff;

   function automatic logic [CHAN_W-1:0] fix_to_chan(input logic [COEF_W-1:0] sum);
      logic              neg;
      logic [COEF_W-1:0] mag;
      logic [COEF_W-1:0] quo;
      neg = sum[COEF_W-1];
      mag = neg ? (~sum + COEF_W'(1)) : sum;
      quo = mag >> FRAC_BITS;
      if (neg) begin
         quo = ~quo + COEF_W'(1);
      end
      return quo[CHAN_W-1:0];
   endfunction

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         for (int m = 0; m < KERNEL_DIM; m++) begin
            for (int n = 0; n < KERNEL_DIM; n++) begin
               prod_in[c][m][n] = COEF_W'(taps[m][n][c*CHAN_W +: CHAN_W]) * kernel[m][n];
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         acc[c] = '0;
         for (int m = 0; m < KERNEL_DIM; m++) begin
            for (int n = 0; n < KERNEL_DIM; n++) begin
               acc[c] = acc[c] + prod_ff[c][m][n];
            end
         end
      end
      pix_out_in.red   = fix_to_chan(acc[0]);
      pix_out_in.green = fix_to_chan(acc[1]);
      pix_out_in.blue  = fix_to_chan(acc[2]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff    <= prod_in;
         last_s2_ff <= last;
      end
      if (ctrl.sum_en) begin
         pix_out_ff  <= pix_out_in;
         last_out_ff <= last_s2_ff;
      end
   end

   assign pix_out  = pix_out_ff;
   assign last_out = last_out_ff;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the RGB 3x3 convolution core with line buffering
// Pixel words are fed through the input stream and the kernel registers and
// frame sizes are set through the register port. A predictor in the bench
// keeps its own line memory and counters and works out each filtered pixel.
// Every result word is checked against it. A short set of frames at the
// extremes comes first, and then random frames. Some frames have random
// padding, and some have registers rewritten in mid-frame. Both streams
// stall at random, except in one phase that runs with no idle cycles.
// ----------------------------------------------------------------------------
module tb
   import rgbcv_pkg::*;
;

   localparam int RANDOM_ITEMS = 1540;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      pixel_type pix;
      logic      last;
   } filtered_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIX_W-1:0]       req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [PIX_W-1:0]       rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rgb_conv3x3_line_buffer_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Register copies and filter state of the predictor.
   logic [CSR_DATA_W-1:0] kernel_rows [KERNEL_DIM];
   logic [WIDTH_W-1:0]    reg_width  = RESET_WIDTH;
   logic [HEIGHT_W-1:0]   reg_height = RESET_HEIGHT;
   logic [PIX_W-1:0]      line_mem [KERNEL_DIM * MAX_LINE];
   int unsigned           pix_index    = 0;
   int unsigned           col_out      = 0;
   int unsigned           row_line_top = 0;
   int unsigned           wr_line      = 1;
   int unsigned           wr_col       = 0;
   int unsigned           lat_width    = 640;
   int unsigned           lat_height   = 480;

   filtered_word_type expected_pixels [$];
   logic [PIX_W-1:0]  pending_pixels [$];
   filtered_word_type want;
   pixel_type         got;
   int                queued_count = 0;
   int                fed_count    = 0;
   int                failures     = 0;
   int                idle_pct     = 34;
   int                rsp_hold_req = 0;
   int                hold_left    = 0;
   int                stall_cycles = 0;
   bit                req_accepted = 1'b0;

   function automatic int unsigned clamp_width(input logic [WIDTH_W-1:0] raw);
      if (raw < MIN_WIDTH) return MIN_WIDTH;
      if (raw > MAX_LINE) return MAX_LINE;
      return 32'(raw);
   endfunction

   function automatic int unsigned clamp_height(input logic [HEIGHT_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(raw);
   endfunction

   function automatic int unsigned following_line(input int unsigned ln);
      return (ln == KERNEL_DIM - 1) ? 0 : ln + 1;
   endfunction

   function automatic logic [CHAN_W-1:0] correlate_channel(input int shift, input bit first_row);
      logic [31:0]       acc;
      int unsigned       ln;
      int unsigned       c;
      logic [CHAN_W-1:0] px;
      logic [COEF_W-1:0] cf;
      int                v;
      acc = '0;
      ln  = row_line_top;
      for (int m = 0; m < KERNEL_DIM; m++) begin
         for (int n = 0; n < KERNEL_DIM; n++) begin
            c = col_out + n;
            if (c < 1 || c > lat_width) continue;
            if (first_row && m == 0) continue;
            px  = line_mem[(ln * MAX_LINE + c - 1) % (KERNEL_DIM * MAX_LINE)][shift +: CHAN_W];
            cf  = kernel_rows[m][COEF_W * n +: COEF_W];
            acc = acc + 32'(px) * 32'(cf);
         end
         ln = following_line(ln);
      end
      v = int'($signed(acc[COEF_W-1:0]));
      // Integer division truncates toward zero, as the output does.
      v = v / (1 << FRAC_BITS);
      return v[CHAN_W-1:0];
   endfunction

   function automatic void predict_pixel(input logic [PIX_W-1:0] word);
      int unsigned       i;
      int unsigned       first_out;
      int unsigned       last_out;
      filtered_word_type res;
      if (pix_index == 0) begin
         lat_width  = clamp_width(reg_width);
         lat_height = clamp_height(reg_height);
      end
      i         = pix_index;
      first_out = lat_width + 2;
      last_out  = lat_width * lat_height + lat_width + 1;
      line_mem[wr_line * MAX_LINE + wr_col] = word;
      wr_col++;
      if (wr_col >= lat_width) begin
         wr_col  = 0;
         wr_line = following_line(wr_line);
      end
      if (i >= first_out && i <= last_out) begin
         res.pix.red   = correlate_channel(0, (i - first_out) < lat_width);
         res.pix.green = correlate_channel(CHAN_W, (i - first_out) < lat_width);
         res.pix.blue  = correlate_channel(2 * CHAN_W, (i - first_out) < lat_width);
         res.last      = (i == last_out);
         expected_pixels.push_back(res);
         col_out++;
         if (col_out >= lat_width) begin
            col_out      = 0;
            row_line_top = following_line(row_line_top);
         end
      end
      if (i >= last_out + 1) begin
         pix_index    = 0;
         col_out      = 0;
         row_line_top = 0;
         wr_line      = 1;
         wr_col       = 0;
      end else begin
         pix_index = i + 1;
      end
   endfunction

   task automatic check_field(input string name, input logic [CHAN_W-1:0] exp_v,
                              input logic [CHAN_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         failures++;
      end
   endtask

   // Input driver: a word is held until taken, then the next one may follow a gap.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_accepted = 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         req_accepted = 1'b0;
         if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_pixels.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver, with a long hold-off when one is requested.
   always @(negedge clock) begin
      if (rsp_hold_req != 0) begin
         hold_left    = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Monitor: predicts each accepted input word and checks each result word.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_pixel(req_tdata);
            fed_count++;
            req_accepted = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               failures++;
            end else begin
               want = expected_pixels.pop_front();
               got  = pixel_type'(rsp_tdata);
               check_field("out_red", want.pix.red, got.red);
               check_field("out_green", want.pix.green, got.green);
               check_field("out_blue", want.pix.blue, got.blue);
               check_field("frame_end", {7'd0, want.last}, {7'd0, rsp_tlast});
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_COEF_TOP:     kernel_rows[0] = val;
         CSR_COEF_MID:     kernel_rows[1] = val;
         CSR_COEF_BOT:     kernel_rows[2] = val;
         CSR_IMAGE_WIDTH:  reg_width = val[WIDTH_W-1:0];
         CSR_IMAGE_HEIGHT: reg_height = val[HEIGHT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_word(input logic [PIX_W-1:0] word);
      pending_pixels.push_back(word);
      queued_count++;
   endtask

   // Waits until every queued word is taken and every result has arrived.
   task automatic settle();
      while (fed_count != queued_count) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0080;
         3: return 16'hFF80;
         4: return 16'h0000;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   function automatic logic [CHAN_W-1:0] pick_chan();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   task automatic write_kernel();
      write_reg(CSR_COEF_TOP, {pick_coef(), pick_coef(), pick_coef()});
      write_reg(CSR_COEF_MID, {pick_coef(), pick_coef(), pick_coef()});
      write_reg(CSR_COEF_BOT, {pick_coef(), pick_coef(), pick_coef()});
   endtask

   task automatic write_random_setup();
      write_kernel();
      if ($urandom_range(9) == 0) begin
         write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(3)));
      end else begin
         write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(12, 4)));
      end
      if ($urandom_range(9) == 0) begin
         write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(0));
      end else begin
         write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(5, 1)));
      end
   endtask

   // One frame of pixels and padding; the sizes are those in force at its start.
   task automatic feed_frame(input bit noisy, input bit split);
      int w;
      int h;
      int total;
      int cut;
      w     = clamp_width(reg_width);
      h     = clamp_height(reg_height);
      total = w * h + w + 3;
      cut   = split ? $urandom_range(total - 1, 1) : -1;
      for (int k = 0; k < total; k++) begin
         if (k == cut) begin
            settle();
            write_random_setup();
         end
         if (k < w * h || noisy) begin
            queue_word({pick_chan(), pick_chan(), pick_chan()});
         end else begin
            queue_word('0);
         end
      end
   endtask

   initial begin
      logic [PIX_W-1:0] first_frame [11];
      int               random_start;
      int               phase;
      first_frame = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'hFF00FF,
                      24'hFFFFFF, 24'h000000, 24'h00FF00, 24'h000000,
                      24'h000000, 24'h000000, 24'h000000};
      foreach (line_mem[a]) line_mem[a] = '0;
      foreach (kernel_rows[r]) kernel_rows[r] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest frame with extreme coefficients and nonzero padding.
      write_reg(CSR_COEF_TOP, {16'h8000, 16'h7FFF, 16'h0080});
      write_reg(CSR_COEF_MID, {16'hFF80, 16'h0100, 16'hFFFF});
      write_reg(CSR_COEF_BOT, {16'h0001, 16'h0000, 16'h7FFF});
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(4));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(1));
      foreach (first_frame[k]) queue_word(first_frame[k]);
      settle();

      // Sizes below the minimum, with the top and middle coefficients at their extremes.
      write_reg(CSR_COEF_TOP, {3{16'h7FFF}});
      write_reg(CSR_COEF_MID, {3{16'h8000}});
      write_reg(CSR_COEF_BOT, {3{16'hFFFF}});
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(3));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(0));
      repeat (4) queue_word(24'hFFFFFF);
      repeat (7) queue_word('0);
      settle();

      random_start = queued_count;
      phase        = 0;
      while (queued_count - random_start < RANDOM_ITEMS) begin
         settle();
         idle_pct = (phase == 4) ? 0 : 34;
         write_random_setup();
         if (phase == 7) begin
            rsp_hold_req = HOLD_CYCLES;
            write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(12));
            write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(5));
         end
         repeat ((phase == 4 || phase == 7) ? 3 : $urandom_range(3, 1)) begin
            feed_frame($urandom_range(9) == 0, $urandom_range(5) == 0);
         end
         phase++;
      end
      settle();

      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: rgb_conv3x3_line_buffer_core.f
+incdir+hw/rtl
hw/rtl/rgbcv_pkg.sv
hw/rtl/rgbcv_ram.sv
hw/rtl/rgbcv_filter.sv
hw/rtl/rgb_conv3x3_line_buffer_core.sv
tb/tb.sv
